// File: hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types for the segment intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  // Per-beat control word that travels down the pipeline next to the data.
  typedef struct packed {
    logic valid;
    logic hit;
    logic parallel;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } sit_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/sit_in_if.sv
// ----------------------------------------------------------------------------
// sit_in_if
// Valid/ready channel carrying one segment pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_in_if #(
  parameter int unsigned W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_start_x;
  logic signed [W-1:0] first_start_y;
  logic signed [W-1:0] first_edge_x;
  logic signed [W-1:0] first_edge_y;
  logic signed [W-1:0] second_start_x;
  logic signed [W-1:0] second_start_y;
  logic signed [W-1:0] second_edge_x;
  logic signed [W-1:0] second_edge_y;

  modport source (
    output valid, first_start_x, first_start_y, first_edge_x, first_edge_y,
           second_start_x, second_start_y, second_edge_x, second_edge_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_edge_x, first_edge_y,
           second_start_x, second_start_y, second_edge_x, second_edge_y,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/sit_out_if.sv
// ----------------------------------------------------------------------------
// sit_out_if
// Valid/ready channel carrying one intersection result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_out_if #(
  parameter int unsigned W = 24
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                parallel;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;
  logic                point_saturated;

  modport source (
    output valid, hit, parallel, cross_x, cross_y, point_saturated,
    input  ready
  );
  modport sink (
    input  valid, hit, parallel, cross_x, cross_y, point_saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Determinant, numerators, hit test and dividend forming, six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_front import sit_pkg::*; #(
  parameter int unsigned W = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [W-1:0] p1x_i,
  input  wire logic signed [W-1:0] p1y_i,
  input  wire logic signed [W-1:0] e1x_i,
  input  wire logic signed [W-1:0] e1y_i,
  input  wire logic signed [W-1:0] p2x_i,
  input  wire logic signed [W-1:0] p2y_i,
  input  wire logic signed [W-1:0] e2x_i,
  input  wire logic signed [W-1:0] e2y_i,
  output sit_ctrl_t                ctrl_o,
  output logic        [2*W-1:0]    d_o,
  output logic signed [W-1:0]      px_o,
  output logic signed [W-1:0]      py_o,
  output logic        [2*W-1:0]    remx_o,
  output logic        [2*W-1:0]    remy_o,
  output logic        [W:0]        lowx_o,
  output logic        [W:0]        lowy_o
);

  localparam int unsigned DW = 2 * W;      // |det|
  localparam int unsigned NW = 2 * W + 1;  // |ns|
  localparam int unsigned L  = W + 1;      // low split of |ns|
  localparam int unsigned PW = 3 * W + 1;  // |ns * e|
  localparam int unsigned K  = W + 1;      // quotient bits

  // stage 1: products
  logic signed [W:0]      dx, dy;
  logic                   v1_q;
  logic signed [2*W-1:0]  ma_q, mb_q;
  logic signed [2*W:0]    mc_q, md_q, me_q, mf_q;
  logic signed [W-1:0]    p1x_1_q, p1y_1_q, e1x_1_q, e1y_1_q;

  assign dx = {p1x_i[W-1], p1x_i} - {p2x_i[W-1], p2x_i};
  assign dy = {p1y_i[W-1], p1y_i} - {p2y_i[W-1], p2y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= e2y_i * e1x_i;
      mb_q    <= e2x_i * e1y_i;
      mc_q    <= e2x_i * dy;
      md_q    <= e2y_i * dx;
      me_q    <= e1x_i * dy;
      mf_q    <= e1y_i * dx;
      p1x_1_q <= p1x_i;
      p1y_1_q <= p1y_i;
      e1x_1_q <= e1x_i;
      e1y_1_q <= e1y_i;
    end
  end

  // stage 2: differences
  logic                   v2_q;
  logic signed [2*W:0]    det_q;
  logic signed [2*W+1:0]  ns_q, nt_q;
  logic signed [W-1:0]    p1x_2_q, p1y_2_q, e1x_2_q, e1y_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q   <= {ma_q[2*W-1], ma_q} - {mb_q[2*W-1], mb_q};
      ns_q    <= {mc_q[2*W], mc_q} - {md_q[2*W], md_q};
      nt_q    <= {me_q[2*W], me_q} - {mf_q[2*W], mf_q};
      p1x_2_q <= p1x_1_q;
      p1y_2_q <= p1y_1_q;
      e1x_2_q <= e1x_1_q;
      e1y_2_q <= e1y_1_q;
    end
  end

  // stage 3: sign and magnitude, hit test
  logic                  det_neg, ns_neg, nt_neg;
  logic signed [2*W:0]   det_abs;
  logic signed [2*W+1:0] ns_abs, nt_abs;
  logic [DW-1:0]         dmag;
  logic [NW-1:0]         nsmag, ntmag;
  logic signed [W-1:0]   ex_abs, ey_abs;
  logic                  s_ok, t_ok;

  assign det_neg = det_q[2*W];
  assign ns_neg  = ns_q[2*W+1];
  assign nt_neg  = nt_q[2*W+1];
  assign det_abs = det_neg ? -det_q : det_q;
  assign ns_abs  = ns_neg ? -ns_q : ns_q;
  assign nt_abs  = nt_neg ? -nt_q : nt_q;
  assign dmag    = det_abs[DW-1:0];
  assign nsmag   = ns_abs[NW-1:0];
  assign ntmag   = nt_abs[NW-1:0];
  assign ex_abs  = e1x_2_q[W-1] ? -e1x_2_q : e1x_2_q;
  assign ey_abs  = e1y_2_q[W-1] ? -e1y_2_q : e1y_2_q;
  assign s_ok    = ((nsmag == '0) || (ns_neg == det_neg)) && (nsmag < {1'b0, dmag});
  assign t_ok    = ((ntmag == '0) || (nt_neg == det_neg)) && (ntmag < {1'b0, dmag});

  sit_ctrl_t     c3_q;
  logic [DW-1:0] d3_q;
  logic [NW-1:0] ns3_q;
  logic [W-1:0]  ex3_q, ey3_q;
  logic signed [W-1:0] p1x_3_q, p1y_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
    end else if (en_i) begin
      c3_q.valid    <= v2_q;
      c3_q.hit      <= s_ok && t_ok;
      c3_q.parallel <= (dmag == '0);
      c3_q.neg_x    <= ns_neg ^ e1x_2_q[W-1] ^ det_neg;
      c3_q.neg_y    <= ns_neg ^ e1y_2_q[W-1] ^ det_neg;
      c3_q.ovf_x    <= 1'b0;
      c3_q.ovf_y    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d3_q    <= dmag;
      ns3_q   <= nsmag;
      ex3_q   <= ex_abs;
      ey3_q   <= ey_abs;
      p1x_3_q <= p1x_2_q;
      p1y_3_q <= p1y_2_q;
    end
  end

  // stage 4: split products of |ns| and |e|
  sit_ctrl_t        c4_q;
  logic [DW-1:0]    d4_q;
  logic [L+W-1:0]   pxl_q, pyl_q;
  logic [2*W-1:0]   pxh_q, pyh_q;
  logic signed [W-1:0] p1x_4_q, p1y_4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
    end else if (en_i) begin
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d4_q    <= d3_q;
      pxl_q   <= ns3_q[L-1:0] * ex3_q;
      pyl_q   <= ns3_q[L-1:0] * ey3_q;
      pxh_q   <= ns3_q[NW-1:L] * ex3_q;
      pyh_q   <= ns3_q[NW-1:L] * ey3_q;
      p1x_4_q <= p1x_3_q;
      p1y_4_q <= p1y_3_q;
    end
  end

  // stage 5: merge partial products
  sit_ctrl_t     c5_q;
  logic [DW-1:0] d5_q;
  logic [PW-1:0] nx_q, ny_q;
  logic signed [W-1:0] p1x_5_q, p1y_5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c5_q <= '0;
    end else if (en_i) begin
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d5_q    <= d4_q;
      nx_q    <= {pxh_q, {L{1'b0}}} + {{(PW-L-W){1'b0}}, pxl_q};
      ny_q    <= {pyh_q, {L{1'b0}}} + {{(PW-L-W){1'b0}}, pyl_q};
      p1x_5_q <= p1x_4_q;
      p1y_5_q <= p1y_4_q;
    end
  end

  // stage 6: quotient range check, seed the divider chain
  logic [DW-1:0] topx, topy;
  sit_ctrl_t     ctrl_d;

  assign topx = nx_q[PW-1:K];
  assign topy = ny_q[PW-1:K];

  always_comb begin
    ctrl_d       = c5_q;
    ctrl_d.ovf_x = (topx >= d5_q);
    ctrl_d.ovf_y = (topy >= d5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o    <= d5_q;
      px_o   <= p1x_5_q;
      py_o   <= p1y_5_q;
      remx_o <= topx;
      remy_o <= topy;
      lowx_o <= nx_q[K-1:0];
      lowy_o <= ny_q[K-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sit_cell.sv
// ----------------------------------------------------------------------------
// sit_cell
// One restoring-division step for both axes; yields one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cell import sit_pkg::*; #(
  parameter int unsigned W = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire sit_ctrl_t           ctrl_i,
  input  wire logic [2*W-1:0]      d_i,
  input  wire logic signed [W-1:0] px_i,
  input  wire logic signed [W-1:0] py_i,
  input  wire logic [2*W-1:0]      remx_i,
  input  wire logic [2*W-1:0]      remy_i,
  input  wire logic [W:0]          lowx_i,
  input  wire logic [W:0]          lowy_i,
  input  wire logic [W:0]          qx_i,
  input  wire logic [W:0]          qy_i,
  output sit_ctrl_t                ctrl_o,
  output logic [2*W-1:0]           d_o,
  output logic signed [W-1:0]      px_o,
  output logic signed [W-1:0]      py_o,
  output logic [2*W-1:0]           remx_o,
  output logic [2*W-1:0]           remy_o,
  output logic [W:0]               lowx_o,
  output logic [W:0]               lowy_o,
  output logic [W:0]               qx_o,
  output logic [W:0]               qy_o
);

  localparam int unsigned DW = 2 * W;
  localparam int unsigned K  = W + 1;

  logic [DW:0]   shx, shy, dext, subx, suby;
  logic          gex, gey;

  // bring down the next dividend bit, subtract when it fits
  assign shx  = {remx_i, lowx_i[K-1]};
  assign shy  = {remy_i, lowy_i[K-1]};
  assign dext = {1'b0, d_i};
  assign gex  = (shx >= dext);
  assign gey  = (shy >= dext);
  assign subx = shx - dext;
  assign suby = shy - dext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o    <= d_i;
      px_o   <= px_i;
      py_o   <= py_i;
      remx_o <= gex ? subx[DW-1:0] : shx[DW-1:0];
      remy_o <= gey ? suby[DW-1:0] : shy[DW-1:0];
      lowx_o <= {lowx_i[K-2:0], 1'b0};
      lowy_o <= {lowy_i[K-2:0], 1'b0};
      qx_o   <= {qx_i[K-2:0], gex};
      qy_o   <= {qy_i[K-2:0], gey};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/segment_intersection_unit.sv
// Pipeline from input beat to result:
//   six front stages, one divider cell per quotient bit (COORD_WIDTH + 1), one output stage.
// Throughput: one segment pair per cycle; the whole pipeline holds while a
//   finished result waits at the output register.
// Reset: rst_ni clears all valid flags asynchronously; the pipe comes up empty.
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Two-segment intersection test with crossing point, fixed point, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_unit import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sit_in_if.sink     seg_in,
  sit_out_if.source  seg_out
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned K  = W + 1;
  localparam int unsigned VW = W + 3;

  localparam logic signed [VW-1:0] HiLim = $signed({4'b0000, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] LoLim = $signed({4'b1111, {(W-1){1'b0}}});

  logic en;
  logic out_valid_q;

  assign en           = !out_valid_q || seg_out.ready;
  assign seg_in.ready = en;

  sit_ctrl_t           ctrl_w [K+1];
  logic [DW-1:0]       d_w    [K+1];
  logic signed [W-1:0] px_w   [K+1];
  logic signed [W-1:0] py_w   [K+1];
  logic [DW-1:0]       remx_w [K+1];
  logic [DW-1:0]       remy_w [K+1];
  logic [K-1:0]        lowx_w [K+1];
  logic [K-1:0]        lowy_w [K+1];
  logic [K-1:0]        qx_w   [K+1];
  logic [K-1:0]        qy_w   [K+1];

  sit_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_in.valid),
    .p1x_i   (seg_in.first_start_x),
    .p1y_i   (seg_in.first_start_y),
    .e1x_i   (seg_in.first_edge_x),
    .e1y_i   (seg_in.first_edge_y),
    .p2x_i   (seg_in.second_start_x),
    .p2y_i   (seg_in.second_start_y),
    .e2x_i   (seg_in.second_edge_x),
    .e2y_i   (seg_in.second_edge_y),
    .ctrl_o  (ctrl_w[0]),
    .d_o     (d_w[0]),
    .px_o    (px_w[0]),
    .py_o    (py_w[0]),
    .remx_o  (remx_w[0]),
    .remy_o  (remy_w[0]),
    .lowx_o  (lowx_w[0]),
    .lowy_o  (lowy_w[0])
  );

  assign qx_w[0] = '0;
  assign qy_w[0] = '0;

  for (genvar i = 0; i < K; i++) begin : g_cell
    sit_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_w[i]),
      .d_i    (d_w[i]),
      .px_i   (px_w[i]),
      .py_i   (py_w[i]),
      .remx_i (remx_w[i]),
      .remy_i (remy_w[i]),
      .lowx_i (lowx_w[i]),
      .lowy_i (lowy_w[i]),
      .qx_i   (qx_w[i]),
      .qy_i   (qy_w[i]),
      .ctrl_o (ctrl_w[i+1]),
      .d_o    (d_w[i+1]),
      .px_o   (px_w[i+1]),
      .py_o   (py_w[i+1]),
      .remx_o (remx_w[i+1]),
      .remy_o (remy_w[i+1]),
      .lowx_o (lowx_w[i+1]),
      .lowy_o (lowy_w[i+1]),
      .qx_o   (qx_w[i+1]),
      .qy_o   (qy_w[i+1])
    );
  end

  // offset the start point and clip to the coordinate range
  sit_ctrl_t           cl;
  logic signed [VW-1:0] pxe, pye, qxe, qye, vx, vy;
  logic                satx, saty;
  logic signed [W-1:0] cx, cy, maxv, minv;

  assign cl   = ctrl_w[K];
  assign pxe  = {{(VW-W){px_w[K][W-1]}}, px_w[K]};
  assign pye  = {{(VW-W){py_w[K][W-1]}}, py_w[K]};
  assign qxe  = {2'b00, qx_w[K]};
  assign qye  = {2'b00, qy_w[K]};
  assign vx   = cl.neg_x ? pxe - qxe : pxe + qxe;
  assign vy   = cl.neg_y ? pye - qye : pye + qye;
  assign maxv = {1'b0, {(W-1){1'b1}}};
  assign minv = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    satx = 1'b1;
    saty = 1'b1;
    if (cl.ovf_x) begin
      cx = cl.neg_x ? minv : maxv;
    end else if (vx > HiLim) begin
      cx = maxv;
    end else if (vx < LoLim) begin
      cx = minv;
    end else begin
      cx   = vx[W-1:0];
      satx = 1'b0;
    end
    if (cl.ovf_y) begin
      cy = cl.neg_y ? minv : maxv;
    end else if (vy > HiLim) begin
      cy = maxv;
    end else if (vy < LoLim) begin
      cy = minv;
    end else begin
      cy   = vy[W-1:0];
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seg_out.hit             <= cl.hit && !cl.parallel;
      seg_out.parallel        <= cl.parallel;
      seg_out.cross_x         <= cl.parallel ? '0 : cx;
      seg_out.cross_y         <= cl.parallel ? '0 : cy;
      seg_out.point_saturated <= !cl.parallel && (satx || saty);
    end
  end

  assign seg_out.valid = out_valid_q;

  a_par_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_out.valid && seg_out.parallel |-> !seg_out.hit)
    else $error("parallel result reports a hit");

  a_par_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_out.valid && seg_out.parallel |->
      seg_out.cross_x == '0 && seg_out.cross_y == '0 && !seg_out.point_saturated)
    else $error("parallel result carries a point");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctrl_w[K]))
    else $error("divider chain moved while output stalled");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_w[K].valid))
    else $error("result appeared without a finished beat");

endmodule

`default_nettype wire

// File: bench/tb_segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_unit
// Self-checking bench for the segment intersection unit. A queue-fed driver
// sends segment pairs over the input channel; each accepted beat is run
// through a local exact-integer predictor. A monitor compares every result
// beat, field by field, with the oldest prediction. Both sides idle and stall
// at random in the first two of three phases; the third runs with neither.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW        = 24;
  localparam int unsigned LATENCY   = CW + 8;
  localparam int unsigned RAND_PAIRS = 1880;
  localparam int unsigned MAX_CYCLES = 400000;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  typedef struct packed {
    coord_t p1x, p1y, e1x, e1y, p2x, p2y, e2x, e2y;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t cross_x;
    coord_t cross_y;
    logic   point_saturated;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sit_in_if  #(.W(CW)) seg_in_bus ();
  sit_out_if #(.W(CW)) seg_out_bus ();

  segment_intersection_unit #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_in (seg_in_bus),
    .seg_out(seg_out_bus)
  );

  seg_pair_t   pending_pairs[$];
  crossing_t   expected_crossings[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hits_seen, parallels_seen, sats_seen, results_seen;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offset along one axis: p + trunc(n*e/d), clipped to the coordinate range.
  function automatic coord_t place_axis(wide_t p, wide_t n, wide_t e, wide_t d,
                                        inout logic sat);
    logic [127:0] quot;
    logic         neg;
    wide_t        v;
    wide_t        hi_lim;
    wide_t        lo_lim;
    hi_lim = (wide_t'(1) <<< (CW - 1)) - 1;
    lo_lim = -hi_lim - 1;
    quot = (n < 0 ? -n : n) * (e < 0 ? -e : e) / (d < 0 ? -d : d);
    neg  = (n < 0) ^ (e < 0) ^ (d < 0);
    v    = neg ? p - wide_t'(quot) : p + wide_t'(quot);
    if (v > hi_lim) begin
      sat = 1'b1;
      v   = hi_lim;
    end else if (v < lo_lim) begin
      sat = 1'b1;
      v   = lo_lim;
    end
    return coord_t'(v);
  endfunction

  function automatic logic in_unit(wide_t n, wide_t d);
    return (n == 0 || ((n < 0) == (d < 0))) && ((n < 0 ? -n : n) < (d < 0 ? -d : d));
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    wide_t     dx, dy, det, ns, nt;
    crossing_t r;
    logic      sat;
    dx  = wide_t'(s.p1x) - wide_t'(s.p2x);
    dy  = wide_t'(s.p1y) - wide_t'(s.p2y);
    det = wide_t'(s.e2y) * wide_t'(s.e1x) - wide_t'(s.e2x) * wide_t'(s.e1y);
    r   = '0;
    if (det == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    ns  = wide_t'(s.e2x) * dy - wide_t'(s.e2y) * dx;
    nt  = wide_t'(s.e1x) * dy - wide_t'(s.e1y) * dx;
    sat = 1'b0;
    r.cross_x = place_axis(wide_t'(s.p1x), ns, wide_t'(s.e1x), det, sat);
    r.cross_y = place_axis(wide_t'(s.p1y), ns, wide_t'(s.e1y), det, sat);
    r.hit     = in_unit(ns, det) && in_unit(nt, det);
    r.point_saturated = sat;
    return r;
  endfunction

  task automatic queue_pair(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t s;
    s = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
          coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
    pending_pairs.push_back(s);
  endtask

  function automatic coord_t small_coord(int unsigned span);
    return coord_t'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t   s;
    int unsigned mode;
    int          k;
    mode = $urandom_range(9);
    if (mode < 3) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (mode < 8) begin
      // well-formed pairs near each other: hits are common
      s.p1x = small_coord(4000); s.p1y = small_coord(4000);
      s.e1x = small_coord(8000); s.e1y = small_coord(8000);
      s.p2x = small_coord(4000); s.p2y = small_coord(4000);
      s.e2x = small_coord(8000); s.e2y = small_coord(8000);
    end else if (mode == 8) begin
      // parallel edges
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      k = int'($urandom_range(6)) - 3;
      s.e1x = small_coord(100000); s.e1y = small_coord(100000);
      s.e2x = coord_t'(k * int'(s.e1x)); s.e2y = coord_t'(k * int'(s.e1y));
    end else begin
      // tiny determinant with far starts: drives the point out of range
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s.e1x = small_coord(3); s.e1y = small_coord(3);
      s.e2x = small_coord(3); s.e2y = small_coord(3);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Driver: hold the beat until accepted, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_in_bus.valid          <= 1'b0;
      seg_in_bus.first_start_x  <= '0;
      seg_in_bus.first_start_y  <= '0;
      seg_in_bus.first_edge_x   <= '0;
      seg_in_bus.first_edge_y   <= '0;
      seg_in_bus.second_start_x <= '0;
      seg_in_bus.second_start_y <= '0;
      seg_in_bus.second_edge_x  <= '0;
      seg_in_bus.second_edge_y  <= '0;
    end else begin
      if (seg_in_bus.valid && seg_in_bus.ready) begin
        expected_crossings.push_back(predict_crossing('{
          seg_in_bus.first_start_x, seg_in_bus.first_start_y,
          seg_in_bus.first_edge_x, seg_in_bus.first_edge_y,
          seg_in_bus.second_start_x, seg_in_bus.second_start_y,
          seg_in_bus.second_edge_x, seg_in_bus.second_edge_y}));
      end
      if (!seg_in_bus.valid || seg_in_bus.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          seg_pair_t s;
          s = pending_pairs.pop_front();
          seg_in_bus.valid          <= 1'b1;
          seg_in_bus.first_start_x  <= s.p1x;
          seg_in_bus.first_start_y  <= s.p1y;
          seg_in_bus.first_edge_x   <= s.e1x;
          seg_in_bus.first_edge_y   <= s.e1y;
          seg_in_bus.second_start_x <= s.p2x;
          seg_in_bus.second_start_y <= s.p2y;
          seg_in_bus.second_edge_x  <= s.e2x;
          seg_in_bus.second_edge_y  <= s.e2y;
        end else begin
          seg_in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall on ready, check each result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_out_bus.ready <= 1'b0;
      cycle_count       <= 0;
    end else begin
      cycle_count       <= cycle_count + 1;
      seg_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (seg_out_bus.valid && seg_out_bus.ready) begin
        if (expected_crossings.size() == 0) begin
          mismatch_count++;
          $display("[%0t] result beat with nothing expected", $time);
        end else begin
          crossing_t want;
          want = expected_crossings.pop_front();
          results_seen++;
          hits_seen      += want.hit;
          parallels_seen += want.parallel;
          sats_seen      += want.point_saturated;
          if (seg_out_bus.hit !== want.hit)
            report_mismatch("hit", seg_out_bus.hit, want.hit);
          if (seg_out_bus.parallel !== want.parallel)
            report_mismatch("parallel", seg_out_bus.parallel, want.parallel);
          if (seg_out_bus.cross_x !== want.cross_x)
            report_mismatch("cross_x", seg_out_bus.cross_x, want.cross_x);
          if (seg_out_bus.cross_y !== want.cross_y)
            report_mismatch("cross_y", seg_out_bus.cross_y, want.cross_y);
          if (seg_out_bus.point_saturated !== want.point_saturated)
            report_mismatch("point_saturated", seg_out_bus.point_saturated,
                            want.point_saturated);
        end
      end
      if (cycle_count > MAX_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    results_seen   = 0;
    hits_seen      = 0;
    parallels_seen = 0;
    sats_seen      = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 55;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero edges, crossings on and off the ends, extremes
    queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(0, 0, 256, 0, 128, -128, 0, 256);
    queue_pair(0, 0, 256, 0, 0, -128, 0, 256);
    queue_pair(0, 0, 256, 0, 256, -128, 0, 256);
    queue_pair(0, 0, 256, 0, 128, 0, 0, 256);
    queue_pair(0, 0, 256, 0, 128, 256, 0, 256);
    queue_pair(0, 0, 0, 256, -128, 128, 256, 0);
    queue_pair(0, 0, 256, 512, 100, 100, 512, 1024);
    queue_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    queue_pair(-8388608, -8388608, -8388608, -8388608,
               -8388608, -8388608, -8388608, -8388608);
    queue_pair(8388607, -8388608, 8388607, -8388608, -8388608, 8388607, -8388608, -8388607);
    queue_pair(8388607, 0, 8388607, 1, -8388608, -256, 1, 512);
    queue_pair(-8388608, 0, -8388608, 1, 8388607, 256, 1, -512);
    queue_pair(0, 0, 1, 0, 8388607, -8388608, 0, 1);
    queue_pair(0, 0, 1, 1, 8388607, -8388608, 1, -1);
    queue_pair(-1, -1, -1, -1, 0, 0, -1, 1);
    queue_pair(100, 200, -300, 400, -50, 300, 500, -100);
    queue_pair(0, 0, -256, 0, -128, -128, 0, 256);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 55 : 0;
      recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 7 : 0;
      for (int i = 0; i < RAND_PAIRS / 3; i++)
        pending_pairs.push_back(random_pair());
      while (pending_pairs.size() != 0) @(posedge clk_i);
    end

    while (pending_pairs.size() != 0 || seg_in_bus.valid || expected_crossings.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (expected_crossings.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", expected_crossings.size());
    end

    $display("covered %0d pairs: %0d hits, %0d parallel, %0d clipped points",
             results_seen, hits_seen, parallels_seen, sats_seen);
    $display("three idle/stall phases, %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
